FILE: hw/rtl/ftdd_pkg.sv
// ----------------------------------------------------------------------------
// ftdd_pkg
// Types, constants and helper functions for the frequency tuner with
// decimal display.
// ----------------------------------------------------------------------------
package ftdd_pkg;

	localparam int FREQ_W   = 27;
	localparam int DIGITS   = 8;
	localparam int STEP_CNT = 7;
	localparam int CHARS    = 10;
	localparam int ADDR_W   = 3;

	typedef logic [FREQ_W-1:0]          freq_t;
	typedef logic [2:0]                 step_idx_t;
	typedef logic [3:0]                 pos_t;
	typedef logic [3:0]                 col_t;
	typedef logic [DIGITS-1:0][3:0]     bcd_t;

	localparam freq_t     FREQ_RESET    = FREQ_W'(14000000);
	localparam freq_t     CEILING_RESET = FREQ_W'(44000000);
	localparam freq_t     FREQ_MAX      = FREQ_W'(99999999);
	localparam bcd_t      BCD_RESET     = {4'd1, 4'd4, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0, 4'd0};
	localparam bcd_t      BCD_MAX       = {DIGITS{4'd9}};
	localparam step_idx_t STEP_LAST     = 3'd6;
	localparam pos_t      POS_LAST      = 4'(CHARS - 1);
	localparam logic [5:0] CHAR_ZERO    = 6'd48;
	localparam logic [5:0] CHAR_DOT     = 6'd46;

	// register index carried in paddr[2]
	localparam logic REG_CEILING = 1'b0;

	typedef struct packed {
		logic up_pressed;
		logic down_pressed;
		logic step_pressed;
	} req_t;

	typedef struct packed {
		logic [5:0] display_char;
		pos_t       char_position;
		logic       last_char;
		freq_t      frequency_hz;
		col_t       cursor_column;
	} res_t;

	typedef struct packed {
		bcd_t  digits;
		freq_t freq;
		col_t  col;
	} snap_t;

	function automatic freq_t step_size(step_idx_t idx);
		freq_t s;
		case (idx)
			3'd0: s = FREQ_W'(1);
			3'd1: s = FREQ_W'(10);
			3'd2: s = FREQ_W'(100);
			3'd3: s = FREQ_W'(1000);
			3'd4: s = FREQ_W'(10000);
			3'd5: s = FREQ_W'(100000);
			3'd6: s = FREQ_W'(1000000);
			default: s = FREQ_W'(1);
		endcase
		return s;
	endfunction

	function automatic col_t step_column(step_idx_t idx);
		col_t c;
		case (idx)
			3'd0: c = 4'd9;
			3'd1: c = 4'd8;
			3'd2: c = 4'd7;
			3'd3: c = 4'd5;
			3'd4: c = 4'd4;
			3'd5: c = 4'd3;
			3'd6: c = 4'd1;
			default: c = 4'd9;
		endcase
		return c;
	endfunction

	// add one at digit k, ripple carry upward
	function automatic bcd_t bcd_inc_at(bcd_t d, step_idx_t k);
		bcd_t r;
		logic c;
		r = d;
		c = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (i == int'(k))
				c = 1'b1;
			if (c) begin
				if (d[i] == 4'd9) begin
					r[i] = 4'd0;
				end else begin
					r[i] = d[i] + 4'd1;
					c = 1'b0;
				end
			end
		end
		return r;
	endfunction

	// subtract one at digit k, ripple borrow upward
	function automatic bcd_t bcd_dec_at(bcd_t d, step_idx_t k);
		bcd_t r;
		logic b;
		r = d;
		b = 1'b0;
		for (int i = 0; i < DIGITS; i++) begin
			if (i == int'(k))
				b = 1'b1;
			if (b) begin
				if (d[i] == 4'd0) begin
					r[i] = 4'd9;
				end else begin
					r[i] = d[i] - 4'd1;
					b = 1'b0;
				end
			end
		end
		return r;
	endfunction

endpackage

FILE: hw/rtl/ftdd_tuner.sv
// ----------------------------------------------------------------------------
// ftdd_tuner
// Frequency and step state. Applies up, down and step buttons of one
// request and keeps the frequency in binary and in BCD side by side.
// ----------------------------------------------------------------------------
module ftdd_tuner
	import ftdd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  req_t  req,
	input  freq_t ceiling,
	output snap_t snap
);

	freq_t     freq_q;
	bcd_t      bcd_q;
	step_idx_t idx_q;

	step_idx_t idx_v;
	freq_t     step;
	logic [FREQ_W:0] sum;
	logic      up_ok;
	logic      dn_ok;
	freq_t     f1;
	freq_t     f2;
	bcd_t      b1;
	bcd_t      b2;
	step_idx_t idx_nxt;
	step_idx_t idx_nxt_v;

	always_comb begin
		idx_v = (idx_q > STEP_LAST) ? 3'd0 : idx_q;
		step  = step_size(idx_v);
		up_ok = req.up_pressed && (freq_q <= ceiling);
		sum   = {1'b0, freq_q} + {1'b0, step};
		f1 = freq_q;
		b1 = bcd_q;
		if (up_ok) begin
			if (sum > {1'b0, FREQ_MAX}) begin
				f1 = FREQ_MAX;
				b1 = BCD_MAX;
			end else begin
				f1 = sum[FREQ_W-1:0];
				b1 = bcd_inc_at(bcd_q, idx_v);
			end
		end
		dn_ok = req.down_pressed && (step <= f1);
		f2 = dn_ok ? (f1 - step) : f1;
		b2 = dn_ok ? bcd_dec_at(b1, idx_v) : b1;
		if (req.step_pressed)
			idx_nxt = (idx_v == STEP_LAST) ? 3'd0 : idx_v + 3'd1;
		else
			idx_nxt = idx_q;
		idx_nxt_v = (idx_nxt > STEP_LAST) ? 3'd0 : idx_nxt;
	end

	assign snap.digits = b2;
	assign snap.freq   = f2;
	assign snap.col    = step_column(idx_nxt_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			freq_q <= FREQ_RESET;
			bcd_q  <= BCD_RESET;
			idx_q  <= 3'd0;
		end else if (load) begin
			freq_q <= f2;
			bcd_q  <= b2;
			idx_q  <= idx_nxt;
		end
	end

endmodule

FILE: hw/rtl/ftdd_serializer.sv
// ----------------------------------------------------------------------------
// ftdd_serializer
// Holds one frequency snapshot and sends its ten-character line, one
// character per cycle while res_stall is low, dots at positions 2 and 6.
// ----------------------------------------------------------------------------
module ftdd_serializer
	import ftdd_pkg::*;
(
	input  logic  clk,
	input  logic  arst_n,
	input  logic  load,
	input  snap_t snap,
	output logic  free,
	output logic  res_valid,
	input  logic  res_stall,
	output res_t  res
);

	logic  busy_q;
	pos_t  pos_q;
	snap_t snap_q;
	logic [3:0] dig;
	logic       dot;

	assign free = !busy_q || (pos_q == POS_LAST && !res_stall);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			pos_q  <= '0;
		end else if (load) begin
			busy_q <= 1'b1;
			pos_q  <= '0;
		end else if (busy_q && !res_stall) begin
			if (pos_q == POS_LAST)
				busy_q <= 1'b0;
			else
				pos_q <= pos_q + 4'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load)
			snap_q <= snap;
	end

	always_comb begin
		dot = 1'b0;
		case (pos_q)
			4'd0: dig = snap_q.digits[7];
			4'd1: dig = snap_q.digits[6];
			4'd3: dig = snap_q.digits[5];
			4'd4: dig = snap_q.digits[4];
			4'd5: dig = snap_q.digits[3];
			4'd7: dig = snap_q.digits[2];
			4'd8: dig = snap_q.digits[1];
			4'd9: dig = snap_q.digits[0];
			default: begin
				dig = 4'd0;
				dot = 1'b1;
			end
		endcase
	end

	assign res_valid         = busy_q;
	assign res.display_char  = dot ? CHAR_DOT : CHAR_ZERO + {2'b00, dig};
	assign res.char_position = pos_q;
	assign res.last_char     = (pos_q == POS_LAST);
	assign res.frequency_hz  = snap_q.freq;
	assign res.cursor_column = snap_q.col;

endmodule

FILE: hw/rtl/frequency_tuner_decimal_display_top.sv
// ----------------------------------------------------------------------------
// frequency_tuner_decimal_display_top
// A request is taken into the input register and loaded into the serializer
// when it is free; the serializer sends one character per cycle unless the
// receiver stalls, and the next request waits in the input register meanwhile.
// Reset: ceiling 44000000, frequency 14000000, step 1 (cursor column 9).
// ----------------------------------------------------------------------------
module frequency_tuner_decimal_display_top
	import ftdd_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready,
	input  logic              req_valid,
	output logic              req_stall,
	input  req_t              req,
	output logic              res_valid,
	input  logic              res_stall,
	output res_t              res
);

	freq_t ceiling_q;
	logic  req_v_s1;
	req_t  req_s1;
	logic  free;
	logic  load;
	snap_t snap;

	assign pready = 1'b1;
	assign prdata = (paddr[2] == REG_CEILING) ? {{(32-FREQ_W){1'b0}}, ceiling_q} : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			ceiling_q <= CEILING_RESET;
		else if (psel && penable && pwrite && pready && paddr[2] == REG_CEILING)
			ceiling_q <= pwdata[FREQ_W-1:0];
	end

	assign load      = req_v_s1 && free;
	assign req_stall = req_v_s1 && !free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			req_v_s1 <= 1'b0;
		else if (req_valid && !req_stall)
			req_v_s1 <= 1'b1;
		else if (load)
			req_v_s1 <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (req_valid && !req_stall)
			req_s1 <= req;
	end

	ftdd_tuner u_tuner (
		.clk     (clk),
		.arst_n  (arst_n),
		.load    (load),
		.req     (req_s1),
		.ceiling (ceiling_q),
		.snap    (snap)
	);

	ftdd_serializer u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (load),
		.snap      (snap),
		.free      (free),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

`ifndef SYNTHESIS
	a_load_starts_line: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> res_valid && res.char_position == 4'd0)
		else $error("line does not start at position zero");

	a_line_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_stall && !res.last_char |=>
			res_valid && res.char_position == $past(res.char_position) + 4'd1)
		else $error("line broken or position skipped");

	a_freq_range: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> res.frequency_hz <= FREQ_MAX)
		else $error("frequency above maximum");

	a_last_pos: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res.last_char && res_stall |-> res.char_position == POS_LAST && !load)
		else $error("new line loaded before last character taken");
`endif

endmodule

FILE: sim/frequency_tuner_decimal_display_top_test.sv
// ----------------------------------------------------------------------------
// frequency_tuner_decimal_display_top_test
// Drives button requests and ceiling writes into the tuner. A local model
// tracks frequency, step and ceiling and queues the ten display characters
// each request should produce; every character taken from the block is
// checked field by field against the oldest queued one.
// ----------------------------------------------------------------------------
module frequency_tuner_decimal_display_top_test;
	import ftdd_pkg::*;

	localparam int          STEP_LEVELS = 7;
	localparam int          HOLD_CYCLES = 80;
	localparam int unsigned MHZ_STEP    = 1000000;
	localparam freq_t       CEIL_TOP    = {FREQ_W{1'b1}};
	localparam logic [5:0]  ASCII_ZERO  = 6'd48;
	localparam logic [5:0]  ASCII_DOT   = 6'd46;
	localparam col_t        CURSOR_COL [STEP_LEVELS] = '{
		4'd9, 4'd8, 4'd7, 4'd5, 4'd4, 4'd3, 4'd1
	};

	logic              clk;
	logic              arst_n;
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;
	logic              req_valid;
	logic              req_stall;
	req_t              req;
	logic              res_valid;
	logic              res_stall;
	res_t              res;

	// tuner model
	int unsigned tuned_freq;
	step_idx_t   step_sel;
	int unsigned ceiling_hz;
	res_t        expected_chars[$];

	int mismatch_count;
	bit quiet;
	bit long_hold;

	frequency_tuner_decimal_display_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.req_valid (req_valid),
		.req_stall (req_stall),
		.req       (req),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res)
	);

	always begin
		clk = 1'b1;
		#5;
		clk = 1'b0;
		#5;
	end

	function automatic int unsigned step_hz(step_idx_t idx);
		int unsigned s;
		s = 1;
		if (idx < STEP_LEVELS)
			for (int i = 0; i < int'(idx); i++)
				s = s * 10;
		return s;
	endfunction

	function automatic col_t cursor_of(step_idx_t idx);
		return (idx < STEP_LEVELS) ? CURSOR_COL[idx] : CURSOR_COL[0];
	endfunction

	task automatic report_mismatch(string what, longint got, longint want);
		if (mismatch_count < 100)
			$display("MISMATCH %s: got %0d expected %0d (%0d chars pending)",
				what, got, want, expected_chars.size());
		mismatch_count++;
	endtask

	task automatic predict_line(req_t r);
		int unsigned s;
		int unsigned v;
		res_t        line [CHARS];
		s = step_hz(step_sel);
		if (r.up_pressed && tuned_freq <= ceiling_hz)
			tuned_freq = (tuned_freq + s > FREQ_MAX) ? 32'(FREQ_MAX) : tuned_freq + s;
		if (r.down_pressed && s <= tuned_freq)
			tuned_freq = tuned_freq - s;
		if (r.step_pressed)
			step_sel = (step_sel >= STEP_LAST) ? step_idx_t'(0) : step_sel + 3'd1;
		v = tuned_freq;
		for (int p = CHARS - 1; p >= 0; p--) begin
			if (p == 2 || p == 6) begin
				line[p].display_char = ASCII_DOT;
			end else begin
				line[p].display_char = ASCII_ZERO + 6'(v % 10);
				v = v / 10;
			end
			line[p].char_position = pos_t'(p);
			line[p].last_char     = (p == CHARS - 1);
			line[p].frequency_hz  = freq_t'(tuned_freq);
			line[p].cursor_column = cursor_of(step_sel);
		end
		for (int p = 0; p < CHARS; p++)
			expected_chars.push_back(line[p]);
	endtask

	always @(posedge clk) begin
		res_t want;
		if (arst_n) begin
			if (req_valid && !req_stall)
				predict_line(req);
			if (res_valid && !res_stall) begin
				if (expected_chars.size() == 0) begin
					report_mismatch("character with none expected", res, 0);
				end else begin
					want = expected_chars.pop_front();
					if (res.display_char !== want.display_char)
						report_mismatch("display_char", res.display_char, want.display_char);
					if (res.char_position !== want.char_position)
						report_mismatch("char_position", res.char_position, want.char_position);
					if (res.last_char !== want.last_char)
						report_mismatch("last_char", res.last_char, want.last_char);
					if (res.frequency_hz !== want.frequency_hz)
						report_mismatch("frequency_hz", res.frequency_hz, want.frequency_hz);
					if (res.cursor_column !== want.cursor_column)
						report_mismatch("cursor_column", res.cursor_column, want.cursor_column);
				end
			end
		end
	end

	function automatic int gap_len();
		int k;
		k = $urandom_range(0, 99);
		if (k < 80)
			return $urandom_range(1, 3);
		else if (k < 95)
			return $urandom_range(4, 10);
		return $urandom_range(20, 40);
	endfunction

	// receiver: random stalls, or one long hold-off when asked
	initial begin
		int n;
		res_stall = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold) begin
				res_stall = 1'b1;
				for (n = 0; n < HOLD_CYCLES; n++)
					@(negedge clk);
				long_hold = 1'b0;
				res_stall = 1'b0;
			end else if (!quiet && $urandom_range(0, 3) == 0) begin
				n = gap_len();
				res_stall = 1'b1;
				repeat (n) @(negedge clk);
				res_stall = 1'b0;
			end else begin
				res_stall = 1'b0;
			end
		end
	end

	// all driving tasks start and end just after a falling edge
	task automatic send_request(req_t r);
		int gap;
		gap = (quiet || $urandom_range(0, 9) < 6) ? 0 : gap_len();
		if (gap > 0) begin
			req_valid = 1'b0;
			repeat (gap) @(negedge clk);
		end
		req       = r;
		req_valid = 1'b1;
		do @(posedge clk); while (req_stall);
		@(negedge clk);
	endtask

	task automatic press(bit up, bit down, bit stp);
		req_t r;
		r.up_pressed   = up;
		r.down_pressed = down;
		r.step_pressed = stp;
		send_request(r);
	endtask

	task automatic drain();
		req_valid = 1'b0;
		while (expected_chars.size() != 0)
			@(posedge clk);
		@(negedge clk);
	endtask

	task automatic check_ceiling_readback();
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b0;
		paddr   = {REG_CEILING, 2'b00};
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		if (prdata[FREQ_W-1:0] !== freq_t'(ceiling_hz))
			report_mismatch("ceiling readback", prdata[FREQ_W-1:0], ceiling_hz);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
	endtask

	task automatic write_ceiling(freq_t value);
		psel    = 1'b1;
		penable = 1'b0;
		pwrite  = 1'b1;
		paddr   = {REG_CEILING, 2'b00};
		pwdata  = 32'(value);
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		ceiling_hz = 32'(value);
		@(negedge clk);
		psel    = 1'b0;
		penable = 1'b0;
		pwrite  = 1'b0;
		check_ceiling_readback();
	endtask

	task automatic select_step(step_idx_t target);
		while (step_sel != target)
			press(1'b0, 1'b0, 1'b1);
	endtask

	task automatic test_reset_line();
		check_ceiling_readback();
		press(1'b0, 1'b0, 1'b0);
		drain();
	endtask

	task automatic test_button_combos();
		for (int k = 0; k < 8; k++)
			press(k[2], k[1], k[0]);
		// walk the step through its wrap
		repeat (4) press(1'b0, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_ceiling_limits();
		write_ceiling(freq_t'(tuned_freq));
		press(1'b1, 1'b0, 1'b0);
		press(1'b1, 1'b0, 1'b0);
		drain();
		write_ceiling('0);
		press(1'b1, 1'b0, 1'b0);
		press(1'b1, 1'b1, 1'b0);
		drain();
		write_ceiling(CEIL_TOP);
		press(1'b1, 1'b0, 1'b1);
		drain();
	endtask

	task automatic test_floor();
		int n;
		write_ceiling(freq_t'(98000000));
		select_step(STEP_LAST);
		n = 0;
		while (tuned_freq >= MHZ_STEP && n < 60) begin
			press($urandom_range(0, 7) == 0, 1'b1, 1'b0);
			n++;
		end
		// stay near the bottom while the step size changes at random
		repeat (14)
			press($urandom_range(0, 7) == 0, $urandom_range(0, 3) != 0,
				$urandom_range(0, 2) == 0);
		drain();
	endtask

	task automatic test_random_mix();
		freq_t ceilings [5];
		ceilings[0] = CEILING_RESET;
		ceilings[1] = '0;
		ceilings[2] = freq_t'(98000000);
		ceilings[3] = freq_t'($urandom_range(0, 98000000));
		ceilings[4] = freq_t'($urandom);
		for (int c = 0; c < 5; c++) begin
			write_ceiling(ceilings[c]);
			quiet = (c == 2);
			repeat (15) begin
				press($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
					$urandom_range(0, 1) != 0);
			end
			quiet = 1'b0;
			drain();
		end
	endtask

	task automatic test_backpressure();
		quiet     = 1'b1;
		long_hold = 1'b1;
		repeat (10)
			press($urandom_range(0, 1) != 0, $urandom_range(0, 1) != 0,
				$urandom_range(0, 1) != 0);
		quiet = 1'b0;
		drain();
	endtask

	task automatic test_climb_to_max();
		int n;
		int extra;
		write_ceiling(CEIL_TOP);
		select_step(STEP_LAST);
		n     = 0;
		extra = 0;
		while (extra < 5 && n < 200) begin
			press(1'b1, $urandom_range(0, 7) == 0, 1'b0);
			if (tuned_freq == FREQ_MAX)
				extra++;
			n++;
		end
		drain();
		write_ceiling(CEILING_RESET);
	endtask

	initial begin
		arst_n         = 1'b0;
		psel           = 1'b0;
		penable        = 1'b0;
		pwrite         = 1'b0;
		paddr          = '0;
		pwdata         = '0;
		req_valid      = 1'b0;
		req            = '0;
		quiet          = 1'b0;
		long_hold      = 1'b0;
		mismatch_count = 0;
		tuned_freq     = 32'(FREQ_RESET);
		step_sel       = '0;
		ceiling_hz     = 32'(CEILING_RESET);
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_reset_line();
		test_button_combos();
		test_ceiling_limits();
		test_floor();
		test_random_mix();
		test_backpressure();
		test_climb_to_max();

		drain();
		repeat (20) @(posedge clk);
		if (mismatch_count == 0 && expected_chars.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#10000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
